// File: hw/rtl/anaglyph_offset_alpha_blend_core_macros.svh
`ifndef ANAGLYPH_OFFSET_ALPHA_BLEND_CORE_MACROS_SVH
`define ANAGLYPH_OFFSET_ALPHA_BLEND_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define AOB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define AOB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/aob_pkg.sv
package aob_pkg;

    // Word and field widths.
    localparam int PIX_W     = 32;
    localparam int CH_W      = 8;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 2;
    // Output frame side reaches 511 + 255.
    localparam int CNT_W     = 10;
    // Weighted channel sum c1*a1 + c2*a2 and alpha sum a1 + a2.
    localparam int ACC_W     = 17;
    localparam int SUM_W     = 9;
    // The channel quotient never exceeds 255, so eight restoring steps suffice.
    localparam int DIV_STEPS = 8;
    localparam int STEP_W    = 3;

    localparam logic [PIX_W-1:0] RED_KEEP  = 32'hffff0000;
    localparam logic [PIX_W-1:0] CYAN_KEEP = 32'hff00ffff;
    localparam logic [CH_W-1:0]  ALPHA_MAX = 8'd255;

    localparam logic [CFG_W-1:0] DIM_RESET     = 9'd256;
    // A shift of -256 saturates to -255.
    localparam logic [CFG_W-1:0] SHIFT_MIN_RAW = 9'h100;
    localparam logic [CFG_W-1:0] SHIFT_SAT     = 9'h101;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_SHIFT_X = 2'd2,
        REG_SHIFT_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COORD,
        ST_ADDR,
        ST_READ,
        ST_START,
        ST_BLEND,
        ST_PUSH
    } ctrl_state_t;

    typedef enum logic {
        BL_IDLE,
        BL_DIV
    } blend_state_t;

    typedef struct packed {
        logic             start;
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] cyan;
    } blend_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] pixel;
    } blend_rsp_t;

endpackage

// File: hw/rtl/aob_store.sv
module aob_store
    import aob_pkg::*;
#(
    parameter int DEPTH = 65536,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [PIX_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr_red,
    input  logic [AW-1:0]    rd_addr_cyan,
    output logic [PIX_W-1:0] rd_data_red,
    output logic [PIX_W-1:0] rd_data_cyan
);

    logic [PIX_W-1:0] store_mem [DEPTH];
    logic [PIX_W-1:0] rd_red_reg;
    logic [PIX_W-1:0] rd_cyan_reg;

    // Single write port for loading source pixels.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports, one per displaced copy.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_red_reg  <= store_mem[rd_addr_red];
            rd_cyan_reg <= store_mem[rd_addr_cyan];
        end
    end

    assign rd_data_red  = rd_red_reg;
    assign rd_data_cyan = rd_cyan_reg;

endmodule

// File: hw/rtl/aob_blend.sv
module aob_blend
    import aob_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  blend_req_t req,
    output blend_rsp_t rsp
);

    localparam int LANES = 3;

    blend_state_t      state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              done_reg, done_next;
    logic [ACC_W-1:0]  rem_reg [LANES];
    logic [ACC_W-1:0]  rem_next [LANES];
    logic [CH_W-1:0]   quo_reg [LANES];
    logic [CH_W-1:0]   quo_next [LANES];
    logic [ACC_W-1:0]  den_reg, den_next;
    logic              zero_reg, zero_next;
    logic [2*CH_W-1:0] inv_reg, inv_next;
    logic [PIX_W-1:0]  pixel_reg, pixel_next;
    logic [CH_W-1:0]   a_red;
    logic [CH_W-1:0]   a_cyan;
    logic [SUM_W-1:0]  a_sum;
    logic [ACC_W-1:0]  alpha_div;
    logic [CH_W-1:0]   alpha;

    assign a_red  = req.red[PIX_W-1 -: CH_W];
    assign a_cyan = req.cyan[PIX_W-1 -: CH_W];
    assign a_sum  = SUM_W'(a_red) + SUM_W'(a_cyan);

    // Product of the transparencies divided by 255: (x + (x >> 8) + 1) >> 8 is exact
    // over the range of the product.
    assign alpha_div = ACC_W'(inv_reg) + ACC_W'(inv_reg >> CH_W) + ACC_W'(1);
    assign alpha     = ALPHA_MAX - alpha_div[2*CH_W-1 -: CH_W];

    // Setup on start, then one quotient bit per cycle on all three channels.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        den_next   = den_reg;
        zero_next  = zero_reg;
        inv_next   = inv_reg;
        pixel_next = pixel_reg;
        for (int l = 0; l < LANES; l++)
        begin
            rem_next[l] = rem_reg[l];
            quo_next[l] = quo_reg[l];
        end

        unique case (state_reg)
            BL_IDLE:
            begin
                if (req.start)
                begin
                    for (int l = 0; l < LANES; l++)
                    begin
                        rem_next[l] = ACC_W'(req.red[l*CH_W +: CH_W]) * ACC_W'(a_red)
                                    + ACC_W'(req.cyan[l*CH_W +: CH_W]) * ACC_W'(a_cyan);
                        quo_next[l] = '0;
                    end
                    den_next   = ACC_W'(a_sum) << (DIV_STEPS - 1);
                    zero_next  = (a_sum == '0);
                    inv_next   = (2*CH_W)'(ALPHA_MAX - a_red) * (2*CH_W)'(ALPHA_MAX - a_cyan);
                    step_next  = '0;
                    state_next = BL_DIV;
                end
            end
            BL_DIV:
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    if (rem_reg[l] >= den_reg)
                    begin
                        rem_next[l] = rem_reg[l] - den_reg;
                        quo_next[l] = {quo_reg[l][CH_W-2:0], 1'b1};
                    end
                    else
                    begin
                        quo_next[l] = {quo_reg[l][CH_W-2:0], 1'b0};
                    end
                end
                den_next  = den_reg >> 1;
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    // Both alphas zero: every channel is zero.
                    for (int l = 0; l < LANES; l++)
                    begin
                        pixel_next[l*CH_W +: CH_W] = zero_reg ? {CH_W{1'b0}} : quo_next[l];
                    end
                    pixel_next[PIX_W-1 -: CH_W] = alpha;
                    done_next  = 1'b1;
                    state_next = BL_IDLE;
                end
            end
            default:
            begin
                state_next = BL_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BL_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    // Datapath state.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rem_reg[l] <= rem_next[l];
            quo_reg[l] <= quo_next[l];
        end
        den_reg   <= den_next;
        zero_reg  <= zero_next;
        inv_reg   <= inv_next;
        pixel_reg <= pixel_next;
    end

    assign rsp.done  = done_reg;
    assign rsp.pixel = pixel_reg;

endmodule

// File: hw/rtl/anaglyph_offset_alpha_blend_core.sv
// Red-cyan anaglyph by alpha blending of two displaced copies of one stored frame.
// A word with mode 0 writes source_pixel into the frame store at the next row-major
// position without leaving the idle state. A word with mode 1 returns the next pixel
// of the (width+|shift_x|) by (height+|shift_y|) output frame, walked column by
// column, with frame_end high on its last pixel. Each request occupies the block
// from acceptance until its result is handed on: the sequencer places the pixel,
// forms both store addresses and reads the single frame store, whose read ports
// are registered, then runs the eight-step restoring divider that forms the
// alpha-weighted channel means, and waits for a free output register to hand the
// result on. The output register lets the next word enter while a result still
// waits downstream. The frame store is not cleared by reset; only entries that have
// been loaded may be read. Registers may only be written while the block is idle.
module anaglyph_offset_alpha_blend_core
    import aob_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 mode,
    input  logic [PIX_W-1:0]     source_pixel,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [PIX_W-1:0]     out_pixel,
    output logic                 frame_end,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = AW + 1;

    ctrl_state_t state_reg, state_next;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [CFG_W-1:0] shift_x_reg;
    logic [CFG_W-1:0] shift_y_reg;

    logic [AW-1:0]    lp_reg, lp_next;
    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;

    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] j_reg;
    logic             last_reg;
    logic [CFG_W-1:0] xr_reg, yr_reg, xc_reg, yc_reg;
    logic             red_ok_reg, cyan_ok_reg;
    logic [AW-1:0]    addr_red_reg, addr_cyan_reg;
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_pixel_reg;
    logic             frame_end_reg;

    logic [CFG_W-1:0]   width_eff, height_eff;
    logic [CFG_W-1:0]   shift_x_eff, shift_y_eff;
    logic [CFG_W-1:0]   neg_shift_x, neg_shift_y;
    logic [CFG_W-2:0]   mag_x, mag_y;
    logic [CFG_W-2:0]   red_off_x, red_off_y, cyan_off_x, cyan_off_y;
    logic [CNT_W-1:0]   out_w, out_h;
    logic [PW-1:0]      total;
    logic [AW-1:0]      lp_cur;
    logic [PW-1:0]      lp_inc;
    logic               wrap;
    logic [CNT_W-1:0]   i_cur, j_cur, row_inc, col_inc;
    logic               last_cur;
    logic signed [CNT_W:0] x_red, y_red, x_cyan, y_cyan;
    logic               red_ok, cyan_ok;

    logic             store_wr_en;
    logic             pix_req;
    logic             rd_en;
    logic             blend_start;
    logic             out_load;
    logic             out_free;
    logic [PIX_W-1:0] rd_red, rd_cyan;
    blend_req_t       blend_req;
    blend_rsp_t       blend_rsp;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= DIM_RESET;
            height_reg  <= DIM_RESET;
            shift_x_reg <= '0;
            shift_y_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WIDTH:   width_reg   <= cfg_data;
                REG_HEIGHT:  height_reg  <= cfg_data;
                REG_SHIFT_X: shift_x_reg <= cfg_data;
                REG_SHIFT_Y: shift_y_reg <= cfg_data;
                default:     width_reg   <= width_reg;
            endcase
        end
    end

    // Effective image size: zero counts as one, larger values saturate.
    always_comb
    begin
        if (width_reg == '0)
            width_eff = CFG_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            width_eff = CFG_W'(MAX_WIDTH);
        else
            width_eff = width_reg;

        if (height_reg == '0)
            height_eff = CFG_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            height_eff = CFG_W'(MAX_HEIGHT);
        else
            height_eff = height_reg;
    end

    // Shift magnitude and which copy it offsets.
    assign shift_x_eff = (shift_x_reg == SHIFT_MIN_RAW) ? SHIFT_SAT : shift_x_reg;
    assign shift_y_eff = (shift_y_reg == SHIFT_MIN_RAW) ? SHIFT_SAT : shift_y_reg;
    assign neg_shift_x = '0 - shift_x_eff;
    assign neg_shift_y = '0 - shift_y_eff;
    assign mag_x = shift_x_eff[CFG_W-1] ? neg_shift_x[CFG_W-2:0] : shift_x_eff[CFG_W-2:0];
    assign mag_y = shift_y_eff[CFG_W-1] ? neg_shift_y[CFG_W-2:0] : shift_y_eff[CFG_W-2:0];
    assign red_off_x  = shift_x_eff[CFG_W-1] ? mag_x : '0;
    assign red_off_y  = shift_y_eff[CFG_W-1] ? mag_y : '0;
    assign cyan_off_x = shift_x_eff[CFG_W-1] ? '0 : mag_x;
    assign cyan_off_y = shift_y_eff[CFG_W-1] ? '0 : mag_y;

    assign out_w = CNT_W'(width_eff) + CNT_W'(mag_x);
    assign out_h = CNT_W'(height_eff) + CNT_W'(mag_y);

    // Load position with wrap at the image size.
    assign total  = PW'(width_eff) * PW'(height_eff);
    assign lp_cur = ({1'b0, lp_reg} >= total) ? '0 : lp_reg;
    assign lp_inc = {1'b0, lp_cur} + PW'(1);
    assign lp_next = (lp_inc >= total) ? '0 : lp_inc[AW-1:0];

    // Output position, restarting when it lies outside the current frame.
    always_comb
    begin
        wrap     = (col_reg >= out_w) || (row_reg >= out_h);
        i_cur    = wrap ? '0 : col_reg;
        j_cur    = wrap ? '0 : row_reg;
        last_cur = (i_cur == out_w - CNT_W'(1)) && (j_cur == out_h - CNT_W'(1));
        row_inc  = j_cur + CNT_W'(1);
        col_inc  = i_cur + CNT_W'(1);
        if (row_inc >= out_h)
        begin
            row_next = '0;
            col_next = (col_inc >= out_w) ? '0 : col_inc;
        end
        else
        begin
            row_next = row_inc;
            col_next = i_cur;
        end
    end

    // Source coordinates of both copies and their in-image checks.
    always_comb
    begin
        x_red  = $signed({1'b0, i_reg}) - $signed({1'b0, CNT_W'(red_off_x)});
        y_red  = $signed({1'b0, j_reg}) - $signed({1'b0, CNT_W'(red_off_y)});
        x_cyan = $signed({1'b0, i_reg}) - $signed({1'b0, CNT_W'(cyan_off_x)});
        y_cyan = $signed({1'b0, j_reg}) - $signed({1'b0, CNT_W'(cyan_off_y)});
        red_ok = !x_red[CNT_W] && (x_red[CNT_W-1:0] < CNT_W'(width_eff))
              && !y_red[CNT_W] && (y_red[CNT_W-1:0] < CNT_W'(height_eff));
        cyan_ok = !x_cyan[CNT_W] && (x_cyan[CNT_W-1:0] < CNT_W'(width_eff))
               && !y_cyan[CNT_W] && (y_cyan[CNT_W-1:0] < CNT_W'(height_eff));
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer: one word at a time, so a store write never overlaps a read.
    always_comb
    begin
        state_next  = state_reg;
        in_stall    = 1'b1;
        store_wr_en = 1'b0;
        pix_req     = 1'b0;
        rd_en       = 1'b0;
        blend_start = 1'b0;
        out_load    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (mode)
                    begin
                        pix_req    = 1'b1;
                        state_next = ST_COORD;
                    end
                    else
                    begin
                        store_wr_en = 1'b1;
                    end
                end
            end
            ST_COORD:
            begin
                state_next = ST_ADDR;
            end
            ST_ADDR:
            begin
                state_next = ST_READ;
            end
            ST_READ:
            begin
                rd_en      = 1'b1;
                state_next = ST_START;
            end
            ST_START:
            begin
                blend_start = 1'b1;
                state_next  = ST_BLEND;
            end
            ST_BLEND:
            begin
                if (blend_rsp.done)
                begin
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lp_reg        <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (store_wr_en)
            begin
                lp_reg <= lp_next;
            end
            if (pix_req)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Per-request datapath registers.
    always_ff @(posedge clk)
    begin
        if (pix_req)
        begin
            i_reg    <= i_cur;
            j_reg    <= j_cur;
            last_reg <= last_cur;
        end
        if (state_reg == ST_COORD)
        begin
            xr_reg      <= x_red[CFG_W-1:0];
            yr_reg      <= y_red[CFG_W-1:0];
            xc_reg      <= x_cyan[CFG_W-1:0];
            yc_reg      <= y_cyan[CFG_W-1:0];
            red_ok_reg  <= red_ok;
            cyan_ok_reg <= cyan_ok;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_red_reg  <= AW'(PW'(yr_reg) * PW'(width_eff) + PW'(xr_reg));
            addr_cyan_reg <= AW'(PW'(yc_reg) * PW'(width_eff) + PW'(xc_reg));
        end
        if (out_load)
        begin
            out_pixel_reg <= blend_rsp.pixel;
            frame_end_reg <= last_reg;
        end
    end

    aob_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .clk          (clk),
        .wr_en        (store_wr_en),
        .wr_addr      (lp_cur),
        .wr_data      (source_pixel),
        .rd_en        (rd_en),
        .rd_addr_red  (addr_red_reg),
        .rd_addr_cyan (addr_cyan_reg),
        .rd_data_red  (rd_red),
        .rd_data_cyan (rd_cyan)
    );

    // Positions outside the image read as zero.
    assign blend_req.start = blend_start;
    assign blend_req.red   = red_ok_reg ? (rd_red & RED_KEEP) : '0;
    assign blend_req.cyan  = cyan_ok_reg ? (rd_cyan & CYAN_KEEP) : '0;

    aob_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (blend_req),
        .rsp   (blend_rsp)
    );

    assign out_valid = out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: hw/rtl/aob_checker.sv
`include "anaglyph_offset_alpha_blend_core_macros.svh"

module aob_checker
    import aob_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             mode,
    input logic             out_valid,
    input logic             out_stall,
    input logic [PIX_W-1:0] out_pixel,
    input logic             frame_end
);

    // A load word never produces an output word.
    `AOB_ASSERT_NEXT(a_load_no_result, clk, rst_n, in_valid && !in_stall && !mode && !out_valid, !out_valid, "load word produced an output word")

    // A pixel request occupies the block in the following cycle.
    `AOB_ASSERT_NEXT(a_request_busy, clk, rst_n, in_valid && !in_stall && mode, in_stall, "input taken right after a pixel request")

    // A new output word appears only after the block was busy working on it.
    `AOB_ASSERT_SAME(a_result_after_busy, clk, rst_n, $rose(out_valid), $past(in_stall), "output word appeared without a busy period")

    // A stalled output word holds.
    `AOB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel) && $stable(frame_end), "stalled output word changed")

endmodule

bind anaglyph_offset_alpha_blend_core aob_checker u_aob_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_pixel (out_pixel),
    .frame_end (frame_end)
);

// File: test/tb.sv
`timescale 1ns / 1ps

import aob_pkg::*;

localparam logic        MODE_LOAD  = 1'b0;
localparam logic        MODE_EMIT  = 1'b1;
localparam int unsigned IMG_MAX    = 256;
localparam int unsigned STORE_SIZE = IMG_MAX * IMG_MAX;

// One expected output word.
typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
} emitted_t;

// Tracks the frame store, the load and output counters and the registers, and
// holds the blended pixels that are still due from the block.
class anaglyph_tracker;
    logic [PIX_W-1:0] frame_mem [STORE_SIZE];
    bit               loaded [STORE_SIZE];
    logic [CFG_W-1:0] regs [4];
    int unsigned      load_pos;
    int unsigned      col;
    int unsigned      row;
    emitted_t         pending[$];
    int unsigned      words_taken;
    int unsigned      pixels_checked;
    int unsigned      errors;

    function new();
        regs[REG_WIDTH]   = DIM_RESET;
        regs[REG_HEIGHT]  = DIM_RESET;
        regs[REG_SHIFT_X] = '0;
        regs[REG_SHIFT_Y] = '0;
        load_pos = 0;
        col = 0;
        row = 0;
        words_taken = 0;
        pixels_checked = 0;
        errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
        regs[idx] = v;
    endfunction

    // Zero counts as one, anything above the store side saturates.
    function int unsigned dim_of(logic [CFG_W-1:0] v);
        if (v == 0)
            return 1;
        return (v > IMG_MAX) ? IMG_MAX : int'(v);
    endfunction

    // A raw shift of -256 saturates to -255.
    function int shift_of(logic [CFG_W-1:0] v);
        int s;
        s = $signed(v);
        return (s < -255) ? -255 : s;
    endfunction

    function int unsigned img_w();
        return dim_of(regs[REG_WIDTH]);
    endfunction

    function int unsigned img_h();
        return dim_of(regs[REG_HEIGHT]);
    endfunction

    function int unsigned image_size();
        return img_w() * img_h();
    endfunction

    function int unsigned frame_size();
        int sx;
        int sy;
        sx = shift_of(regs[REG_SHIFT_X]);
        sy = shift_of(regs[REG_SHIFT_Y]);
        return (img_w() + (sx < 0 ? -sx : sx)) * (img_h() + (sy < 0 ? -sy : sy));
    endfunction

    function bit on_image(int x, int y);
        return x >= 0 && y >= 0 && x < int'(img_w()) && y < int'(img_h());
    endfunction

    // Position of the next output pixel and the source positions of both copies.
    function void locate(output int unsigned i, j, ow, oh, output int rx, ry, cx, cy);
        int sx;
        int sy;
        sx = shift_of(regs[REG_SHIFT_X]);
        sy = shift_of(regs[REG_SHIFT_Y]);
        ow = img_w() + (sx < 0 ? -sx : sx);
        oh = img_h() + (sy < 0 ? -sy : sy);
        if (col >= ow || row >= oh)
        begin
            i = 0;
            j = 0;
        end
        else
        begin
            i = col;
            j = row;
        end
        rx = int'(i) - (sx < 0 ? -sx : 0);
        ry = int'(j) - (sy < 0 ? -sy : 0);
        cx = int'(i) - (sx > 0 ? sx : 0);
        cy = int'(j) - (sy > 0 ? sy : 0);
    endfunction

    function bit readable(int x, int y);
        if (!on_image(x, y))
            return 1'b1;
        return loaded[y * int'(img_w()) + x];
    endfunction

    function logic [PIX_W-1:0] source_at(int x, int y);
        if (!on_image(x, y))
            return '0;
        return frame_mem[y * int'(img_w()) + x];
    endfunction

    // True when the next output pixel reads only store entries that hold data.
    function bit can_emit();
        int unsigned i, j, ow, oh;
        int rx, ry, cx, cy;
        locate(i, j, ow, oh, rx, ry, cx, cy);
        return readable(rx, ry) && readable(cx, cy);
    endfunction

    function int unsigned mix_channel(int unsigned c1, a1, c2, a2);
        if (a1 + a2 == 0)
            return 0;
        return (c1 * a1 + c2 * a2) / (a1 + a2);
    endfunction

    function logic [PIX_W-1:0] blend_pixels(logic [PIX_W-1:0] p1, logic [PIX_W-1:0] p2);
        int unsigned a1, a2, a;
        logic [PIX_W-1:0] res;
        a1 = p1[31:24];
        a2 = p2[31:24];
        a = 255 - ((255 - a1) * (255 - a2)) / 255;
        res[31:24] = a[7:0];
        res[23:16] = mix_channel(p1[23:16], a1, p2[23:16], a2);
        res[15:8]  = mix_channel(p1[15:8], a1, p2[15:8], a2);
        res[7:0]   = mix_channel(p1[7:0], a1, p2[7:0], a2);
        return res;
    endfunction

    // Applies one accepted input word.
    function void note_word(logic m, logic [PIX_W-1:0] p);
        int unsigned total, i, j, ow, oh;
        int rx, ry, cx, cy;
        emitted_t e;
        words_taken++;
        if (m == MODE_LOAD)
        begin
            total = image_size();
            if (load_pos >= total)
                load_pos = 0;
            frame_mem[load_pos] = p;
            loaded[load_pos] = 1'b1;
            load_pos++;
            if (load_pos >= total)
                load_pos = 0;
            return;
        end
        locate(i, j, ow, oh, rx, ry, cx, cy);
        e.pixel = blend_pixels(source_at(rx, ry) & RED_KEEP, source_at(cx, cy) & CYAN_KEEP);
        e.last = (i == ow - 1) && (j == oh - 1);
        pending.push_back(e);
        // Rows advance first, then columns.
        col = i;
        row = j + 1;
        if (row >= oh)
        begin
            row = 0;
            col++;
            if (col >= ow)
                col = 0;
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 100)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    task check_pixel(logic [PIX_W-1:0] pix, logic fe);
        emitted_t e;
        pixels_checked++;
        if (pending.size() == 0)
        begin
            report($sformatf("output word %h with no pixel pending", pix));
            return;
        end
        e = pending.pop_front();
        if (pix !== e.pixel)
            report($sformatf("out_pixel %h, expected %h", pix, e.pixel));
        if (fe !== e.last)
            report($sformatf("frame_end %b, expected %b", fe, e.last));
    endtask
endclass

module tb;

    localparam int unsigned WORD_TARGET   = 1150;
    localparam int unsigned PIXEL_TARGET  = 48;
    localparam int unsigned SETTLE_CYCLES = 20;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 mode;
    logic [PIX_W-1:0]     source_pixel;
    logic                 out_valid;
    logic                 out_stall;
    logic [PIX_W-1:0]     out_pixel;
    logic                 frame_end;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    anaglyph_tracker tracker;
    bit              calm_in;
    bit              calm_out;

    anaglyph_offset_alpha_blend_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .source_pixel (source_pixel),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_pixel    (out_pixel),
        .frame_end    (frame_end),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    // Hard limit on the whole run.
    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Idle cycles before a word; a calm side never waits.
    function int unsigned draw_gap(bit calm);
        if (calm)
            return 0;
        return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : $urandom_range(0, 2);
    endfunction

    // Random pixel with the fully transparent and fully opaque alphas favored.
    function logic [PIX_W-1:0] draw_pixel();
        logic [PIX_W-1:0] p;
        p = $urandom;
        case ($urandom_range(0, 5))
            0: p[31:24] = 8'h00;
            1: p[31:24] = 8'hff;
            default: ;
        endcase
        return p;
    endfunction

    function logic [CFG_W-1:0] draw_small_shift();
        int s;
        s = int'($urandom_range(0, 10)) - 5;
        return s[CFG_W-1:0];
    endfunction

    // Drives one input word after a random gap and waits until it is taken.
    task send_word(logic m, logic [PIX_W-1:0] p);
        int unsigned gap;
        gap = draw_gap(calm_in);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            mode = $urandom;
            source_pixel = $urandom;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        mode = m;
        source_pixel = p;
        do
            @(posedge clk);
        while (in_stall);
        tracker.note_word(m, p);
    endtask

    // Holds the input back until every pending pixel has come out.
    task settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(cfg_reg_t idx, logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        tracker.set_reg(idx, v);
    endtask

    // Writes the registers whose skip bit is clear, with the block idle.
    task configure(logic [CFG_W-1:0] w, h, sx, sy, bit [3:0] skip);
        settle();
        if (!skip[0])
            write_reg(REG_WIDTH, w);
        if (!skip[1])
            write_reg(REG_HEIGHT, h);
        if (!skip[2])
            write_reg(REG_SHIFT_X, sx);
        if (!skip[3])
            write_reg(REG_SHIFT_Y, sy);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // One setting followed by a mix of loads and pixel requests. The first few
    // phases force the largest sizes and shifts.
    task run_phase(int unsigned ph);
        logic [CFG_W-1:0] wr, hr, xr, yr;
        bit [3:0]         skip;
        int unsigned      kind, n, k;
        logic             m;
        kind = (ph < 3) ? ph : $urandom_range(0, 19);
        wr = $urandom_range(0, 6);
        hr = $urandom_range(0, 6);
        xr = draw_small_shift();
        yr = draw_small_shift();
        case (kind)
            0:
            begin
                wr = (ph == 0) ? 9'h1ff : $urandom_range(256, 511);
                hr = $urandom_range(0, 1);
            end
            1:
            begin
                wr = $urandom_range(0, 1);
                hr = (ph == 1) ? 9'd256 : $urandom_range(256, 511);
            end
            2:
            begin
                wr = $urandom_range(0, 2);
                hr = $urandom_range(1, 3);
                xr = ($urandom_range(0, 1) != 0) ? 9'd255 : SHIFT_MIN_RAW;
                yr = ($urandom_range(0, 1) != 0) ? 9'd255 : SHIFT_SAT;
            end
            default: ;
        endcase
        skip = '0;
        if (ph >= 3 && $urandom_range(0, 3) == 0)
            skip[3:2] = $urandom;
        configure(wr, hr, xr, yr, skip);
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);

        n = tracker.image_size();
        if (tracker.frame_size() <= 160)
            n += tracker.frame_size() + $urandom_range(0, 8);
        else
            n += $urandom_range(20, 50);
        for (k = 0; k < n; k++)
        begin
            // A request that would read an empty store entry becomes a load.
            m = ($urandom_range(0, 9) < 7) ? MODE_EMIT : MODE_LOAD;
            if (m == MODE_EMIT && !tracker.can_emit())
                m = MODE_LOAD;
            send_word(m, draw_pixel());
            if ($urandom_range(0, 60) == 0)
                settle();
        end
    endtask

    // Output side: random stall before each word, check on acceptance.
    initial
    begin : output_side
        int unsigned k;
        @(posedge rst_n);
        forever
        begin
            k = draw_gap(calm_out);
            if (k != 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (k) @(negedge clk);
                out_stall = 1'b0;
            end
            do
                @(posedge clk);
            while (!out_valid);
            tracker.check_pixel(out_pixel, frame_end);
        end
    end

    // Main stimulus.
    initial
    begin : input_side
        int unsigned ph;
        int unsigned k;
        tracker = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        mode = MODE_LOAD;
        source_pixel = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        calm_in = 1'b0;
        calm_out = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 2 by 2 image, cyan right and up. Five loads wrap onto the first entry,
        // two transparent pixels meet at one output position, and ten requests
        // run past the end of the 3 by 3 frame.
        configure(9'd2, 9'd2, 9'd1, 9'h1ff, 4'b0000);
        send_word(MODE_LOAD, 32'h0000_0000);
        send_word(MODE_LOAD, 32'h00ff_ffff);
        send_word(MODE_LOAD, 32'h00a5_5a5a);
        send_word(MODE_LOAD, 32'hffff_ffff);
        send_word(MODE_LOAD, 32'h80c0_3f01);
        for (k = 0; k < 10; k++)
            send_word(MODE_EMIT, 32'hffff_ffff);
        settle();

        // Width zero, saturated left shift, largest downward shift.
        configure(9'd0, 9'd2, SHIFT_MIN_RAW, 9'd255, 4'b0000);
        send_word(MODE_LOAD, 32'hff80_40c0);
        send_word(MODE_LOAD, 32'h7f01_fe33);
        for (k = 0; k < 8; k++)
            send_word(MODE_EMIT, '0);

        ph = 0;
        while (tracker.words_taken < WORD_TARGET || tracker.pixels_checked < PIXEL_TARGET)
        begin
            run_phase(ph);
            ph++;
        end

        settle();
        if (tracker.pending.size() != 0)
            tracker.report("pixels still pending at the end");
        if (tracker.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
